// ===== hdl/fixed_point_exp_scale_interp_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the exponential scale block
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_EXP_SCALE_INTERP_DEFINES_SVH
`define FIXED_POINT_EXP_SCALE_INTERP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FPESI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define FPESI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fpesi_pkg.sv =====
// ----------------------------------------------------------------------------
// fpesi_pkg
// Constants, operand bundle and multiplier operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpesi_pkg;

  localparam int VALUE_BITS = 32;
  localparam int EXP_BITS   = 16;
  localparam int FRAC_BITS  = 5;
  localparam int STEP_BITS  = EXP_BITS - FRAC_BITS;
  localparam int POW_SHIFT  = 12;
  localparam int POW_BITS   = VALUE_BITS - POW_SHIFT;
  localparam int SPAN_BITS  = VALUE_BITS - FRAC_BITS;
  localparam int OUT_BITS   = 20;

  localparam logic [POW_BITS-1:0] POW_ONE = POW_BITS'(32'h0000_1000);
  localparam logic [POW_BITS-1:0] GROWTH  = POW_BITS'(32'h0000_103B);

  typedef enum logic [1:0] {
    MUL_POW,
    MUL_LO,
    MUL_HI,
    MUL_FRAC
  } mul_op_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [POW_BITS-1:0]   p_lo;
    logic [POW_BITS-1:0]   p_hi;
    logic [SPAN_BITS-1:0]  span;
    logic [FRAC_BITS-1:0]  frac;
  } mul_opnd_t;

endpackage

// ===== hdl/fpesi_mul.sv =====
// ----------------------------------------------------------------------------
// fpesi_mul
// Shared 32x32 multiplier, low word only, with operand select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpesi_mul import fpesi_pkg::*; (
  input  mul_op_t               op,
  input  mul_opnd_t             opnd,
  output logic [VALUE_BITS-1:0] prod
);

  logic [VALUE_BITS-1:0] op_a;
  logic [VALUE_BITS-1:0] op_b;

  always_comb begin
    unique case (op)
      MUL_POW: begin
        op_a = VALUE_BITS'(opnd.p_hi);
        op_b = VALUE_BITS'(GROWTH);
      end
      MUL_LO: begin
        op_a = opnd.value;
        op_b = VALUE_BITS'(opnd.p_lo);
      end
      MUL_HI: begin
        op_a = opnd.value;
        op_b = VALUE_BITS'(opnd.p_hi);
      end
      MUL_FRAC: begin
        op_a = VALUE_BITS'(opnd.span);
        op_b = VALUE_BITS'(opnd.frac);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = VALUE_BITS'(op_a * op_b);

endmodule

// ===== hdl/fpesi_seq.sv =====
// ----------------------------------------------------------------------------
// fpesi_seq
// Sequencer: power stepping, end products, interpolation and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpesi_seq import fpesi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [EXP_BITS-1:0]   exponent,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   scaled,
  output mul_op_t               op,
  output mul_opnd_t             opnd,
  input  logic [VALUE_BITS-1:0] prod
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POW,
    S_LO,
    S_HI,
    S_SUM
  } state_t;

  state_t                state;
  logic [STEP_BITS-1:0]  count;
  logic [VALUE_BITS-1:0] val;
  logic [POW_BITS-1:0]   p_lo;
  logic [POW_BITS-1:0]   p_hi;
  logic [FRAC_BITS-1:0]  frac;
  logic [VALUE_BITS-1:0] a;
  logic [SPAN_BITS-1:0]  span;
  logic [VALUE_BITS-1:0] diff;
  logic [VALUE_BITS-1:0] sum;
  logic [STEP_BITS-1:0]  steps_in;
  logic                  out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign steps_in = exponent[EXP_BITS-1:FRAC_BITS];
  assign diff     = prod - a;
  assign sum      = a + prod;

  assign opnd.value = val;
  assign opnd.p_lo  = p_lo;
  assign opnd.p_hi  = p_hi;
  assign opnd.span  = span;
  assign opnd.frac  = frac;

  always_comb begin
    unique case (state)
      S_LO:    op = MUL_LO;
      S_HI:    op = MUL_HI;
      S_SUM:   op = MUL_FRAC;
      default: op = MUL_POW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val   <= value;
            frac  <= exponent[FRAC_BITS-1:0];
            count <= steps_in;
            p_lo  <= POW_ONE;
            p_hi  <= GROWTH;
            state <= (steps_in == '0) ? S_LO : S_POW;
          end
        end
        S_POW: begin
          p_lo  <= p_hi;
          p_hi  <= prod[VALUE_BITS-1:POW_SHIFT];
          count <= count - 1'b1;
          if (count == STEP_BITS'(1)) begin
            state <= S_LO;
          end
        end
        S_LO: begin
          a     <= prod;
          state <= S_HI;
        end
        S_HI: begin
          span  <= diff[VALUE_BITS-1:FRAC_BITS];
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            scaled <= sum[VALUE_BITS-1:POW_SHIFT];
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/fixed_point_exp_scale_interp.sv =====
// Flow: a taken word runs through N power steps, the low and high products
// and the interpolated sum, where N = exponent >> 5 is the count of whole
// steps (0 to 2047); no new word is taken until its result is registered.
// The power recurrence runs one step per cycle on the single shared multiplier.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// fixed_point_exp_scale_interp
// Scales an unsigned word by 0x103B/4096 raised to a fractional power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_exp_scale_interp_defines.svh"

module fixed_point_exp_scale_interp import fpesi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [EXP_BITS-1:0]   exponent,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   scaled
);

  mul_op_t               op;
  mul_opnd_t             opnd;
  logic [VALUE_BITS-1:0] prod;

  fpesi_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scaled    (scaled),
    .op        (op),
    .opnd      (opnd),
    .prod      (prod)
  );

  fpesi_mul u_mul (
    .op   (op),
    .opnd (opnd),
    .prod (prod)
  );

  `FPESI_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "not busy after take")
  `FPESI_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result while idle")
  `FPESI_ASSERT_NOW(a_idle_mul_op, !in_stall, op == MUL_POW, "operand select off in idle")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fractional-power scale block. A scoreboard
// computes each expected scaled word from the power recurrence and the linear
// interpolation. It compares every output word in order. Directed corner
// words come first, then randomized words with bursty idling on both sides, a
// long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

class scale_scoreboard;
  logic [fpesi_pkg::OUT_BITS-1:0] pending_scaled[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic [fpesi_pkg::OUT_BITS-1:0] scale_word(
      logic [31:0] v, logic [fpesi_pkg::EXP_BITS-1:0] e);
    logic [31:0] steps;
    logic [31:0] frac;
    logic [31:0] p_lo;
    logic [31:0] p_hi;
    logic [31:0] prod;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] span;
    logic [31:0] s;
    steps = 32'(e) >> fpesi_pkg::FRAC_BITS;
    frac  = 32'(e) & 32'h0000_001F;
    p_lo  = 32'h0000_1000;
    p_hi  = 32'h0000_103B;
    for (int i = 0; i < steps; i++) begin
      p_lo = p_hi;
      prod = p_hi * 32'h0000_103B;
      p_hi = prod >> fpesi_pkg::POW_SHIFT;
    end
    a    = v * p_lo;
    b    = v * p_hi;
    span = (b - a) >> fpesi_pkg::FRAC_BITS;
    prod = span * frac;
    s    = a + prod;
    return s[31:12];
  endfunction

  function void note_input(logic [31:0] v, logic [fpesi_pkg::EXP_BITS-1:0] e);
    pending_scaled.push_back(scale_word(v, e));
  endfunction

  function void check_result(logic [fpesi_pkg::OUT_BITS-1:0] actual);
    logic [fpesi_pkg::OUT_BITS-1:0] want;
    if (pending_scaled.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual scaled=%h", $time, actual);
    end else begin
      want = pending_scaled.pop_front();
      if (want !== actual) begin
        errors++;
        $display("%0t: scaled mismatch, expected %h, actual %h", $time, want, actual);
      end
    end
  endfunction
endclass

module tb;
  import fpesi_pkg::*;

  localparam int HOLD_CYCLES = 500;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_WORDS = 242;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value = '0;
  logic [EXP_BITS-1:0]   exponent = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_BITS-1:0]   scaled;

  scale_scoreboard board;
  bit  idle_on = 1'b1;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  cycles = 0;

  fixed_point_exp_scale_interp dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scaled    (scaled)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      burst_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(scaled);
    end
  end

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 511)) - 32'd256;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXP_BITS-1:0] rand_exponent();
    case ($urandom_range(0, 19))
      0, 1, 2: return EXP_BITS'($urandom);
      3, 4, 5: return EXP_BITS'($urandom_range(0, 16'h3FFF));
      default: return EXP_BITS'($urandom_range(0, 16'h07FF));
    endcase
  endfunction

  task automatic send_word(logic [31:0] v, logic [EXP_BITS-1:0] e, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    exponent <= e;
    do @(posedge clk); while (in_stall);
    board.note_input(v, e);
  endtask

  task automatic wait_drained();
    while (board.pending_scaled.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(32'h0000_0000, 16'h0000, pick_gap());
    send_word(32'h0000_0001, 16'h0000, pick_gap());
    send_word(32'hFFFF_FFFF, 16'h0001, pick_gap());
    send_word(32'h7FFF_FFFF, 16'h001F, pick_gap());
    send_word(32'h8000_0000, 16'h001F, pick_gap());
    send_word(32'h0000_1000, 16'h0020, pick_gap());
    send_word(32'hFFFF_F000, 16'h0021, pick_gap());
    send_word(32'h1234_5678, 16'h003F, pick_gap());
    send_word(32'hFFFF_FF80, 16'h011F, pick_gap());
    send_word(32'h8000_0000, 16'h8000, pick_gap());
    send_word(32'h7FFF_FFFF, 16'hFFE0, pick_gap());
    send_word(32'hFFFF_FFFF, 16'hFFFF, pick_gap());
    send_word(32'h0000_0001, 16'hFFFF, pick_gap());
    send_word(32'h8000_0000, 16'h7FFF, pick_gap());
    send_word(32'hA5A5_A5A5, 16'h5555, pick_gap());
    send_word(32'h5A5A_5A5A, 16'hAAAA, pick_gap());
    send_word(32'hFFFF_FFFF, 16'h0800, pick_gap());
    send_word(32'h0001_0000, 16'h1000, pick_gap());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 60) begin
        hold_request = 1'b1;
        for (int k = 0; k < 30; k++) begin
          send_word(rand_value(), EXP_BITS'($urandom_range(0, 255)), 0);
        end
      end
      if (n == 120) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
      if (n == 150) idle_on = 1'b0;
      if (n == 180) idle_on = 1'b1;
      if (n == 200) idle_on = 1'b0;
      send_word(rand_value(), rand_exponent(), pick_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained();
    repeat (2100) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
